>>> rtl/core/tlfs_pkg.sv
`default_nettype none

package tlfs_pkg;

	localparam int MAX_PROCS  = 16;
	localparam int MAX_IOS    = 8;
	localparam int PIDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PCNT_W     = $clog2(MAX_PROCS + 1);
	localparam int IOIDX_W    = (MAX_IOS > 1) ? $clog2(MAX_IOS) : 1;
	localparam int IOCNT_W    = $clog2(MAX_IOS + 1);
	localparam int IOADDR_W   = PIDX_W + IOIDX_W;
	localparam int IO_DEPTH   = 2 ** IOADDR_W;
	localparam int CLK_W      = 20;
	localparam int PID_W      = 16;
	localparam int CPU_W      = 16;
	localparam int SET_W      = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int NUM_Q      = 6;
	localparam int QIDX_W     = 3;
	localparam int NUM_DEV    = 3;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);

	localparam logic [CLK_W-1:0] CLOCK_MAX = '1;

	// queue codes
	localparam logic [QIDX_W-1:0] Q_ARR  = 3'd0;
	localparam logic [QIDX_W-1:0] Q_HIGH = 3'd1;
	localparam logic [QIDX_W-1:0] Q_LOW  = 3'd2;
	localparam logic [QIDX_W-1:0] Q_DISK = 3'd3;

	// item kinds
	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_IO   = 2'd1;
	localparam logic [1:0] KIND_RUN  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// device codes
	localparam logic [1:0] DEV_DISK    = 2'd0;
	localparam logic [1:0] DEV_TAPE    = 2'd1;
	localparam logic [1:0] DEV_PRINTER = 2'd2;

	// outcomes
	localparam logic [2:0] OUT_IDLE     = 3'd0;
	localparam logic [2:0] OUT_TO_LOW   = 3'd1;
	localparam logic [2:0] OUT_FINISHED = 3'd2;
	localparam logic [2:0] OUT_DISK     = 3'd3;
	localparam logic [2:0] OUT_LOADED   = 3'd6;
	localparam logic [2:0] OUT_FULL     = 3'd7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISK    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAPE    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRINTER = 8'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [PID_W-1:0] pid;
		logic [CLK_W-1:0] arrival_time;
		logic [CPU_W-1:0] cpu_total;
		logic [1:0]       io_device;
		logic [CPU_W-1:0] io_moment;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARR,
		ST_DEV,
		ST_PICK,
		ST_CALC,
		ST_DECIDE,
		ST_ADV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/tlfs_item_if.sv
`default_nettype none

interface tlfs_item_if import tlfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [PID_W-1:0] pid;
	logic [CLK_W-1:0] arrival_time;
	logic [CPU_W-1:0] cpu_total;
	logic [1:0]       io_device;
	logic [CPU_W-1:0] io_moment;

	modport source (output valid, kind, pid, arrival_time, cpu_total, io_device, io_moment,
		input ready);
	modport sink (input valid, kind, pid, arrival_time, cpu_total, io_device, io_moment,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/tlfs_res_if.sv
`default_nettype none

interface tlfs_res_if import tlfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PID_W-1:0] run_pid;
	logic [CLK_W-1:0] start_tick;
	logic [SET_W-1:0] run_length;
	logic [2:0]       outcome;
	logic [CLK_W-1:0] clock_now;
	logic             all_done;

	modport source (output valid, run_pid, start_tick, run_length, outcome, clock_now, all_done,
		input ready);
	modport sink (input valid, run_pid, start_tick, run_length, outcome, clock_now, all_done,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/tlfs_cfg_if.sv
`default_nettype none

interface tlfs_cfg_if import tlfs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SET_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tlfs_queue.sv
`default_nettype none

// Circular FIFO of process slots, front readable at all times.
module tlfs_queue import tlfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              pop,
	input  logic [PIDX_W-1:0] push_pid,
	output logic [PIDX_W-1:0] front,
	output logic [PCNT_W-1:0] count
);

	logic [PIDX_W-1:0] slot_q [MAX_PROCS];
	logic [PIDX_W-1:0] head_q;
	logic [PCNT_W-1:0] count_q;
	logic [PCNT_W:0]   tail_sum;
	logic [PIDX_W-1:0] tail;
	logic              do_push;
	logic              do_pop;

	assign do_push  = push && (count_q < PCNT_W'(MAX_PROCS));
	assign do_pop   = pop && (count_q != '0);
	assign tail_sum = (PCNT_W + 1)'(head_q) + (PCNT_W + 1)'(count_q);
	assign tail     = (tail_sum >= (PCNT_W + 1)'(MAX_PROCS)) ?
		PIDX_W'(tail_sum - (PCNT_W + 1)'(MAX_PROCS)) : PIDX_W'(tail_sum);
	assign front    = slot_q[head_q];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_pop) begin
				head_q <= (head_q == PIDX_W'(MAX_PROCS - 1)) ? '0 : head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[tail] <= push_pid;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tlfs_cmd_fifo.sv
`default_nettype none

// Short command queue between the front and the back.
module tlfs_cmd_fifo import tlfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic avail,
	output cmd_t head_cmd
);

	cmd_t                mem_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0]  wr_q;
	logic [CMDQ_PW-1:0]  rd_q;
	logic [CMDQ_PW:0]    cnt_q;

	assign full     = (cnt_q == (CMDQ_PW + 1)'(CMDQ_DEPTH));
	assign avail    = (cnt_q != '0);
	assign head_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && avail) begin
				rd_q <= rd_q + 1'b1;
			end
			if ((push && !full) && !(pop && avail)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && (pop && avail)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tlfs_front.sv
`default_nettype none

// Takes items, drops the unused kind, packs the rest as commands.
module tlfs_front import tlfs_pkg::*; (
	tlfs_item_if.sink item,
	input  logic      cmdq_full,
	output logic      cmd_push,
	output cmd_t      cmd
);

	assign item.ready = !cmdq_full;
	assign cmd_push   = item.valid && !cmdq_full && (item.kind != KIND_NONE);

	always_comb begin
		cmd.kind         = item.kind;
		cmd.pid          = item.pid;
		cmd.arrival_time = item.arrival_time;
		cmd.cpu_total    = item.cpu_total;
		cmd.io_device    = item.io_device;
		cmd.io_moment    = item.io_moment;
	end

endmodule

`default_nettype wire

>>> rtl/core/tlfs_back.sv
`default_nettype none

// Executes commands: loads, and scheduling rounds stepped one queue move per cycle.
module tlfs_back import tlfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_avail,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	tlfs_cfg_if.sink    cfg,
	tlfs_res_if.source  result
);

	// settings
	logic [SET_W-1:0] quantum_q, disk_svc_q, tape_svc_q, prn_svc_q;

	// process table
	logic [PID_W-1:0]   pid_mem   [MAX_PROCS];
	logic [CPU_W-1:0]   total_mem [MAX_PROCS];
	logic [CPU_W-1:0]   used_mem  [MAX_PROCS];
	logic [CLK_W-1:0]   stamp_mem [MAX_PROCS];
	logic [IOCNT_W-1:0] iocnt_mem [MAX_PROCS];
	logic [IOCNT_W-1:0] nextio_mem[MAX_PROCS];
	logic [17:0]        io_mem    [IO_DEPTH];
	logic [17:0]        io_rd_q;

	// control
	state_t            state_q, state_d;
	logic [CLK_W-1:0]  clock_q;
	logic [CLK_W-1:0]  dfree_q [NUM_DEV];
	logic [PCNT_W-1:0] proc_count_q, fin_count_q;
	logic              ticking_q;
	logic [1:0]        dev_q;
	logic [SET_W-1:0]  rem_q;
	logic              out_valid_q;

	// round working registers
	logic [PIDX_W-1:0] p_q;
	logic [CPU_W-1:0]  rest_q, to_io_q;
	logic              has_io_q;
	logic [1:0]        dev_sel_q;
	logic [QIDX_W-1:0] dest_q;
	logic              fin_q;
	logic [PID_W-1:0]  res_pid_q;
	logic [CLK_W-1:0]  res_start_q;
	logic [SET_W-1:0]  res_len_q;
	logic [2:0]        res_outcome_q;

	// output register
	logic [PID_W-1:0]  out_pid_q;
	logic [CLK_W-1:0]  out_start_q, out_clock_q;
	logic [SET_W-1:0]  out_len_q;
	logic [2:0]        out_outcome_q;
	logic              out_done_q;

	// queues
	logic [NUM_Q-1:0]  q_push, q_pop;
	logic [PIDX_W-1:0] push_pid;
	logic [PIDX_W-1:0] q_front [NUM_Q];
	logic [PCNT_W-1:0] q_count [NUM_Q];

	for (genvar g = 0; g < NUM_Q; g++) begin : g_q
		tlfs_queue u_queue (
			.clk      (clk),
			.arst_n   (arst_n),
			.push     (q_push[g]),
			.pop      (q_pop[g]),
			.push_pid (push_pid),
			.front    (q_front[g]),
			.count    (q_count[g])
		);
	end

	// shared datapath terms
	logic              out_free;
	logic [QIDX_W-1:0] dev_code;
	logic [PIDX_W-1:0] arr_p, dev_p, pick_p, last_p, new_p;
	logic [CLK_W-1:0]  stamp_rd, dfree_rd, df;
	logic [SET_W-1:0]  svc;
	logic [CLK_W:0]    dev_sum;
	logic              arr_ok, dev_ne, dev_ok, high_ne, low_ne;
	logic [QIDX_W-1:0] dev_dest;
	logic              add_ok, io_ok;
	logic [IOADDR_W-1:0] io_raddr, io_waddr;
	logic [SET_W-1:0]  delta0, delta;
	logic              take_io;
	logic [CPU_W-1:0]  used_rd, total_rd, moment;

	assign out_free = !out_valid_q || result.ready;
	assign dev_code = Q_DISK + QIDX_W'(dev_q);
	assign arr_p    = q_front[Q_ARR];
	assign dev_p    = q_front[dev_code];
	assign stamp_rd = stamp_mem[(state_q == ST_ARR) ? arr_p : dev_p];
	assign arr_ok   = (q_count[Q_ARR] != '0) && (stamp_rd <= clock_q);
	assign dfree_rd = dfree_q[dev_q];
	assign df       = (stamp_rd > dfree_rd) ? stamp_rd : dfree_rd;
	assign dev_ne   = (q_count[dev_code] != '0);
	assign dev_sum  = (CLK_W + 1)'(df) + (CLK_W + 1)'(svc);
	assign dev_ok   = dev_ne && (dev_sum <= (CLK_W + 1)'(clock_q));
	assign dev_dest = (dev_q == DEV_DISK) ? Q_LOW : Q_HIGH;
	assign high_ne  = (q_count[Q_HIGH] != '0);
	assign low_ne   = (q_count[Q_LOW] != '0);
	assign pick_p   = high_ne ? q_front[Q_HIGH] : q_front[Q_LOW];
	assign last_p   = PIDX_W'(proc_count_q - 1'b1);
	assign new_p    = PIDX_W'(proc_count_q);
	assign add_ok   = (proc_count_q < PCNT_W'(MAX_PROCS));
	assign io_ok    = (proc_count_q != '0) && (iocnt_mem[last_p] < IOCNT_W'(MAX_IOS));
	assign io_raddr = {pick_p, IOIDX_W'(nextio_mem[pick_p])};
	assign io_waddr = {last_p, IOIDX_W'(iocnt_mem[last_p])};
	assign used_rd  = used_mem[p_q];
	assign total_rd = total_mem[p_q];
	assign moment   = io_rd_q[CPU_W-1:0];
	assign delta0   = (rest_q < CPU_W'(quantum_q)) ? SET_W'(rest_q) : quantum_q;
	assign take_io  = has_io_q && (CPU_W'(delta0) >= to_io_q);
	assign delta    = take_io ? SET_W'(to_io_q) : delta0;

	always_comb begin
		case (dev_q)
			DEV_DISK: svc = disk_svc_q;
			DEV_TAPE: svc = tape_svc_q;
			default:  svc = prn_svc_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_avail) begin
					state_d = (cmd.kind == KIND_RUN) ? ST_ARR : ST_DONE;
				end
			end
			ST_ARR: begin
				if (!arr_ok) begin
					state_d = ST_DEV;
				end
			end
			ST_DEV: begin
				if (!dev_ok && dev_q == DEV_PRINTER) begin
					state_d = ticking_q ? ST_ADV : ST_PICK;
				end
			end
			ST_PICK:   state_d = (high_ne || low_ne) ? ST_CALC : ST_DONE;
			ST_CALC:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_ADV;
			ST_ADV: begin
				state_d = (rem_q != '0 && clock_q != CLOCK_MAX) ? ST_ARR : ST_FIN;
			end
			ST_FIN:    state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// queue and handshake controls
	always_comb begin
		cmd_pop  = 1'b0;
		q_push   = '0;
		q_pop    = '0;
		push_pid = p_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop  = cmd_avail;
				push_pid = new_p;
				if (cmd_avail && cmd.kind == KIND_ADD && add_ok) begin
					q_push[Q_ARR] = 1'b1;
				end
			end
			ST_ARR: begin
				push_pid = arr_p;
				if (arr_ok) begin
					q_pop[Q_ARR]   = 1'b1;
					q_push[Q_HIGH] = 1'b1;
				end
			end
			ST_DEV: begin
				push_pid = dev_p;
				if (dev_ok) begin
					q_pop[dev_code]  = 1'b1;
					q_push[dev_dest] = 1'b1;
				end
			end
			ST_PICK: begin
				if (high_ne) begin
					q_pop[Q_HIGH] = 1'b1;
				end else if (low_ne) begin
					q_pop[Q_LOW] = 1'b1;
				end
			end
			ST_FIN: begin
				if (!fin_q) begin
					q_push[dest_q] = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg.ready = 1'b1;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clock_q      <= '0;
			for (int i = 0; i < NUM_DEV; i++) begin
				dfree_q[i] <= '0;
			end
			proc_count_q <= '0;
			fin_count_q  <= '0;
			ticking_q    <= 1'b0;
			dev_q        <= DEV_DISK;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
			quantum_q    <= 8'd5;
			disk_svc_q   <= 8'd5;
			tape_svc_q   <= 8'd10;
			prn_svc_q    <= 8'd15;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_QUANTUM: quantum_q  <= cfg.data;
					REG_DISK:    disk_svc_q <= cfg.data;
					REG_TAPE:    tape_svc_q <= cfg.data;
					REG_PRINTER: prn_svc_q  <= cfg.data;
					default: begin
					end
				endcase
			end
			// a new result loads as the previous one leaves
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					ticking_q <= 1'b0;
					if (cmd_avail && cmd.kind == KIND_ADD && add_ok) begin
						proc_count_q <= proc_count_q + 1'b1;
					end
				end
				ST_ARR: begin
					dev_q <= DEV_DISK;
				end
				ST_DEV: begin
					if (dev_ok) begin
						dfree_q[dev_q] <= CLK_W'(dev_sum);
					end else begin
						if (dev_ne) begin
							dfree_q[dev_q] <= df;
						end
						if (dev_q != DEV_PRINTER) begin
							dev_q <= dev_q + 1'b1;
						end
					end
				end
				ST_PICK: begin
					if (!high_ne && !low_ne && clock_q != CLOCK_MAX) begin
						clock_q <= clock_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					rem_q <= delta;
				end
				ST_ADV: begin
					if (rem_q != '0 && clock_q != CLOCK_MAX) begin
						clock_q   <= clock_q + 1'b1;
						rem_q     <= rem_q - 1'b1;
						ticking_q <= 1'b1;
					end
				end
				ST_FIN: begin
					if (fin_q) begin
						fin_count_q <= fin_count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// tables and payload
	always_ff @(posedge clk) begin
		io_rd_q <= io_mem[io_raddr];
		unique case (state_q)
			ST_IDLE: begin
				res_pid_q   <= '0;
				res_start_q <= '0;
				res_len_q   <= '0;
				res_outcome_q <= OUT_FULL;
				if (cmd_avail && cmd.kind == KIND_ADD && add_ok) begin
					pid_mem[new_p]    <= cmd.pid;
					stamp_mem[new_p]  <= cmd.arrival_time;
					total_mem[new_p]  <= cmd.cpu_total;
					used_mem[new_p]   <= '0;
					iocnt_mem[new_p]  <= '0;
					nextio_mem[new_p] <= '0;
					res_outcome_q     <= OUT_LOADED;
				end
				if (cmd_avail && cmd.kind == KIND_IO && io_ok) begin
					io_mem[io_waddr]  <= {cmd.io_device, cmd.io_moment};
					iocnt_mem[last_p] <= iocnt_mem[last_p] + 1'b1;
					res_outcome_q     <= OUT_LOADED;
				end
			end
			ST_DEV: begin
				if (dev_ok) begin
					stamp_mem[dev_p] <= CLK_W'(dev_sum);
				end
			end
			ST_PICK: begin
				p_q           <= pick_p;
				res_start_q   <= clock_q;
				res_pid_q     <= '0;
				res_len_q     <= '0;
				res_outcome_q <= OUT_IDLE;
			end
			ST_CALC: begin
				rest_q    <= (total_rd > used_rd) ? total_rd - used_rd : '0;
				to_io_q   <= (moment > used_rd) ? moment - used_rd : '0;
				has_io_q  <= (nextio_mem[p_q] < iocnt_mem[p_q]);
				dev_sel_q <= (io_rd_q[17:16] > DEV_PRINTER) ? DEV_PRINTER : io_rd_q[17:16];
			end
			ST_DECIDE: begin
				res_pid_q      <= pid_mem[p_q];
				res_len_q      <= delta;
				used_mem[p_q]  <= used_rd + CPU_W'(delta);
				fin_q          <= 1'b0;
				if (take_io) begin
					nextio_mem[p_q] <= nextio_mem[p_q] + 1'b1;
					dest_q          <= Q_DISK + QIDX_W'(dev_sel_q);
					res_outcome_q   <= OUT_DISK + 3'(dev_sel_q);
				end else if (CPU_W'(delta) < rest_q) begin
					dest_q        <= Q_LOW;
					res_outcome_q <= OUT_TO_LOW;
				end else begin
					dest_q        <= Q_LOW;
					fin_q         <= 1'b1;
					res_outcome_q <= OUT_FINISHED;
				end
			end
			ST_FIN: begin
				if (!fin_q) begin
					stamp_mem[p_q] <= clock_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_pid_q     <= res_pid_q;
					out_start_q   <= res_start_q;
					out_len_q     <= res_len_q;
					out_outcome_q <= res_outcome_q;
					out_clock_q   <= clock_q;
					out_done_q    <= (fin_count_q == proc_count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.run_pid    = out_pid_q;
	assign result.start_tick = out_start_q;
	assign result.run_length = out_len_q;
	assign result.outcome    = out_outcome_q;
	assign result.clock_now  = out_clock_q;
	assign result.all_done   = out_done_q;

	logic [PCNT_W+2:0] q_total;
	always_comb begin
		q_total = '0;
		for (int i = 0; i < NUM_Q; i++) begin
			q_total = q_total + (PCNT_W + 3)'(q_count[i]);
		end
	end

	a_clock_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> clock_q >= $past(clock_q))
		else $error("scheduler clock went backwards");

	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_count_q <= proc_count_q)
		else $error("more finished processes than loaded");

	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEV |-> dev_q <= DEV_PRINTER)
		else $error("device index out of range");

	a_queued_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_total <= (PCNT_W + 3)'(proc_count_q))
		else $error("more queued slots than processes");

	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(q_push))
		else $error("two queue pushes in one cycle");

endmodule

`default_nettype wire

>>> rtl/core/two_level_feedback_scheduler.sv
// A load goes from command pickup through the done state to the result register, where
// a busy result register can hold it. A run round makes queue moves one per cycle for
// arrivals and I/O completions, picks, calculates, decides, then advances the clock per
// tick, rescanning moves; an idle round ends at the pick. Back: one item at a time.
// Reset (arst_n low, async): queues empty, clock, device times and counts zero,
// settings 5/5/10/15; process and I/O tables hold no reset.
`default_nettype none

module two_level_feedback_scheduler import tlfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tlfs_item_if.sink  item,
	tlfs_res_if.source result,
	tlfs_cfg_if.sink   cfg
);

	// Front: takes each item transfer, drops the unused kind and packs a command.
	logic cmdq_full;
	logic cmd_push;
	cmd_t cmd_in;

	tlfs_front u_front (
		.item      (item),
		.cmdq_full (cmdq_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	// Command queue lets the front keep taking items while a round runs.
	logic cmd_avail;
	logic cmd_pop;
	cmd_t cmd_head;

	tlfs_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.full     (cmdq_full),
		.pop      (cmd_pop),
		.avail    (cmd_avail),
		.head_cmd (cmd_head)
	);

	// Back: process table, six FIFOs, clock and device timers; the result
	// register there holds a finished result while the next command starts.
	tlfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (cmd_avail),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

`default_nettype wire

>>> sim/tlfs_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels, keeps a private copy of the
// scheduler state and compares every result transfer with the oldest prediction.
module tlfs_checker import tlfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tlfs_item_if        item,
	tlfs_res_if         result,
	tlfs_cfg_if         cfg,
	output int          errors,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [PID_W-1:0] run_pid;
		logic [CLK_W-1:0] start_tick;
		logic [SET_W-1:0] run_length;
		logic [2:0]       outcome;
		logic [CLK_W-1:0] clock_now;
		logic             all_done;
	} sched_res_t;

	sched_res_t expected_res[$];

	// shadow settings and scheduler state
	int               quantum_set;
	int               svc_set[NUM_DEV];
	logic [PID_W-1:0] m_pid[MAX_PROCS];
	int               m_total[MAX_PROCS];
	int               m_used[MAX_PROCS];
	int               m_stamp[MAX_PROCS];
	int               m_ioc[MAX_PROCS];
	int               m_nio[MAX_PROCS];
	logic [17:0]      m_io[MAX_PROCS*MAX_IOS];
	int               m_slot[NUM_Q][MAX_PROCS];
	int               m_head[NUM_Q];
	int               m_cnt[NUM_Q];
	int               sim_tick;
	int               dev_free[NUM_DEV];
	int               n_procs;
	int               n_done;

	function automatic void q_put(int q, int p);
		if (m_cnt[q] >= MAX_PROCS)
			return;
		m_slot[q][(m_head[q] + m_cnt[q]) % MAX_PROCS] = p;
		m_cnt[q]++;
	endfunction

	function automatic int q_first(int q);
		return m_slot[q][m_head[q]];
	endfunction

	function automatic void q_drop(int q);
		if (m_cnt[q] == 0)
			return;
		m_head[q] = (m_head[q] + 1) % MAX_PROCS;
		m_cnt[q]--;
	endfunction

	function automatic void admit_due();
		int p;
		while (m_cnt[Q_ARR] != 0 && m_stamp[q_first(Q_ARR)] <= sim_tick) begin
			p = q_first(Q_ARR);
			q_drop(Q_ARR);
			q_put(Q_HIGH, p);
		end
	endfunction

	function automatic void retire_io();
		int q;
		int p;
		for (int d = 0; d < NUM_DEV; d++) begin
			q = Q_DISK + d;
			while (m_cnt[q] != 0) begin
				p = q_first(q);
				if (m_stamp[p] > dev_free[d])
					dev_free[d] = m_stamp[p];
				if (dev_free[d] + svc_set[d] > sim_tick)
					break;
				dev_free[d] += svc_set[d];
				q_drop(q);
				m_stamp[p] = dev_free[d];
				q_put((d == 0) ? Q_LOW : Q_HIGH, p);
			end
		end
	endfunction

	function automatic void walk_ticks(int n);
		int target;
		target = sim_tick + n;
		if (target > CLOCK_MAX)
			target = CLOCK_MAX;
		while (sim_tick < target) begin
			sim_tick++;
			admit_due();
			retire_io();
		end
	endfunction

	function automatic sched_res_t schedule_item(logic [1:0] kind, logic [PID_W-1:0] pid,
			logic [CLK_W-1:0] arr, logic [CPU_W-1:0] cpu, logic [1:0] dev,
			logic [CPU_W-1:0] moment);
		sched_res_t r;
		int q, p, used, total, rest, grant, to_io, d;
		bit has_io;
		r = '0;
		if (kind == KIND_ADD) begin
			if (n_procs >= MAX_PROCS) begin
				r.outcome = OUT_FULL;
			end else begin
				p = n_procs;
				m_pid[p] = pid;
				m_stamp[p] = arr;
				m_total[p] = cpu;
				m_used[p] = 0;
				m_ioc[p] = 0;
				m_nio[p] = 0;
				q_put(Q_ARR, p);
				n_procs++;
				r.outcome = OUT_LOADED;
			end
		end else if (kind == KIND_IO) begin
			p = n_procs - 1;
			if (n_procs == 0 || m_ioc[p] >= MAX_IOS) begin
				r.outcome = OUT_FULL;
			end else begin
				m_io[p*MAX_IOS + m_ioc[p]] = {dev, moment};
				m_ioc[p]++;
				r.outcome = OUT_LOADED;
			end
		end else begin
			admit_due();
			retire_io();
			r.start_tick = CLK_W'(sim_tick);
			q = (m_cnt[Q_HIGH] != 0) ? Q_HIGH : (m_cnt[Q_LOW] != 0) ? Q_LOW : -1;
			if (q < 0) begin
				if (sim_tick < CLOCK_MAX)
					sim_tick++;
				r.outcome = OUT_IDLE;
			end else begin
				p = q_first(q);
				q_drop(q);
				used = m_used[p];
				total = m_total[p];
				rest = (total > used) ? total - used : 0;
				grant = (rest < quantum_set) ? rest : quantum_set;
				has_io = m_nio[p] < m_ioc[p];
				to_io = 0;
				r.run_pid = m_pid[p];
				if (has_io) begin
					to_io = m_io[p*MAX_IOS + m_nio[p]][15:0];
					to_io = (to_io > used) ? to_io - used : 0;
				end
				if (has_io && grant >= to_io) begin
					d = m_io[p*MAX_IOS + m_nio[p]][17:16];
					if (d > 2)
						d = 2;
					grant = to_io;
					m_nio[p]++;
					m_used[p] = (used + grant) & 16'hFFFF;
					walk_ticks(grant);
					m_stamp[p] = sim_tick;
					q_put(Q_DISK + d, p);
					r.outcome = OUT_DISK + 3'(d);
				end else begin
					m_used[p] = (used + grant) & 16'hFFFF;
					walk_ticks(grant);
					if (used + grant < total) begin
						m_stamp[p] = sim_tick;
						q_put(Q_LOW, p);
						r.outcome = OUT_TO_LOW;
					end else begin
						n_done++;
						r.outcome = OUT_FINISHED;
					end
				end
				r.run_length = SET_W'(grant);
			end
		end
		r.clock_now = CLK_W'(sim_tick);
		r.all_done = (n_done == n_procs);
		return r;
	endfunction

	assign pending = expected_res.size();

	always @(posedge clk or negedge arst_n) begin
		sched_res_t got, want;
		if (!arst_n) begin
			quantum_set = 5;
			svc_set = '{5, 10, 15};
			for (int i = 0; i < NUM_Q; i++) begin
				m_head[i] = 0;
				m_cnt[i] = 0;
			end
			dev_free = '{0, 0, 0};
			sim_tick = 0;
			n_procs = 0;
			n_done = 0;
			errors = 0;
			checked = 0;
			expected_res.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_QUANTUM: quantum_set = cfg.data;
					REG_DISK:    svc_set[0] = cfg.data;
					REG_TAPE:    svc_set[1] = cfg.data;
					REG_PRINTER: svc_set[2] = cfg.data;
					default: ;
				endcase
			end
			if (item.valid && item.ready && item.kind != KIND_NONE)
				expected_res.push_back(schedule_item(item.kind, item.pid, item.arrival_time,
					item.cpu_total, item.io_device, item.io_moment));
			if (result.valid && result.ready) begin
				got = '{result.run_pid, result.start_tick, result.run_length, result.outcome,
					result.clock_now, result.all_done};
				checked++;
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					errors++;
				end else begin
					want = expected_res.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors++;
					end
				end
			end
		end
	end

endmodule

>>> sim/tb_two_level_feedback_scheduler.sv
`timescale 1ns / 1ps

module tb_two_level_feedback_scheduler;
	import tlfs_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int N_PHASES    = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending, checked;
	int   n_sent = 0;
	int   n_adds = 0;
	int   n_cycles = 0;

	tlfs_item_if item_ch ();
	tlfs_res_if  res_ch ();
	tlfs_cfg_if  cfg_ch ();

	two_level_feedback_scheduler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	tlfs_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (res_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always #1 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stall per transfer, every third stretch of 100 results
	// takes them back to back
	initial begin
		int n_res;
		int stall;
		n_res = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ((n_res / 100) % 3 == 1) ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			n_res++;
		end
	end

	// one item transfer; valid stays up when no gap follows
	task automatic send_item(logic [1:0] kind, logic [PID_W-1:0] pid, logic [CLK_W-1:0] arr,
			logic [CPU_W-1:0] cpu, logic [1:0] dev, logic [CPU_W-1:0] moment);
		int gap;
		gap = ((n_sent / 100) % 3 == 2) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= kind;
		item_ch.pid          <= pid;
		item_ch.arrival_time <= arr;
		item_ch.cpu_total    <= cpu;
		item_ch.io_device    <= dev;
		item_ch.io_moment    <= moment;
		do @(posedge clk); while (!item_ch.ready);
		n_sent++;
		if (kind == KIND_ADD)
			n_adds++;
	endtask

	// wait for every prediction to be matched, plus slack for a trailing unused kind
	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_settings(int qv, int dv, int tv, int pv);
		logic [CFG_IDX_W-1:0] idx[4];
		int vals[4];
		idx = '{REG_QUANTUM, REG_DISK, REG_TAPE, REG_PRINTER};
		vals = '{qv, dv, tv, pv};
		cfg_ch.valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= SET_W'(vals[i]);
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// random item: mostly rounds; the process table fills over the run, and the
	// last process arrives far in the future with maximum cpu so it holds up the
	// arrival FIFO
	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			send_item(KIND_NONE, PID_W'($urandom), CLK_W'($urandom), CPU_W'($urandom),
				2'($urandom), CPU_W'($urandom));
		end else if (sel < ((n_adds < MAX_PROCS) ? 17 : 9)) begin
			if (n_adds == MAX_PROCS - 1)
				send_item(KIND_ADD, PID_W'($urandom), CLK_W'($urandom) | 20'h80000,
					16'hFFFF, 0, 0);
			else
				send_item(KIND_ADD, PID_W'($urandom), CLK_W'($urandom_range(0, 600)),
					CPU_W'($urandom_range(0, 80)), 0, 0);
		end else if (sel < ((n_adds < MAX_PROCS) ? 32 : 14)) begin
			send_item(KIND_IO, 0, 0, 0, 2'($urandom_range(0, 3)),
				CPU_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 90)));
		end else begin
			send_item(KIND_RUN, 0, 0, 0, 0, 0);
		end
	endtask

	initial begin
		int phase_len[N_PHASES];
		int qv, dv, tv, pv;
		phase_len = '{330, 330, 30, 420, 420, 420};
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_NONE;
		item_ch.pid = '0;
		item_ch.arrival_time = '0;
		item_ch.cpu_total = '0;
		item_ch.io_device = '0;
		item_ch.io_moment = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at reset settings
		send_item(KIND_IO, 0, 0, 0, 2'd3, 16'hFFFF);   // no process yet: full
		send_item(KIND_RUN, 0, 0, 0, 0, 0);            // empty system: idle
		send_item(KIND_ADD, 16'hFFFF, 0, 12, 0, 0);
		send_item(KIND_IO, 0, 0, 0, DEV_DISK, 3);
		send_item(KIND_IO, 0, 0, 0, DEV_TAPE, 3);      // already passed when reached
		send_item(KIND_IO, 0, 0, 0, DEV_PRINTER, 8);
		send_item(KIND_IO, 0, 0, 0, 2'd3, 10);          // code 3 also means printer
		for (int i = 0; i < 4; i++)
			send_item(KIND_IO, 0, 0, 0, 2'(i), CPU_W'(11 + i));
		send_item(KIND_IO, 0, 0, 0, DEV_DISK, 20);     // io list already full
		send_item(KIND_ADD, 16'h0000, 2, 0, 0, 0);     // zero cpu process
		send_item(KIND_ADD, 16'h5A5A, 400, 3, 0, 0);   // not due, blocks next one
		send_item(KIND_ADD, 16'hA5A5, 0, 2, 0, 0);
		send_item(KIND_NONE, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 2'd3, 16'hFFFF);
		for (int i = 0; i < 10; i++)
			send_item(KIND_RUN, 0, 0, 0, 0, 0);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin qv = 5; dv = 5; tv = 10; pv = 15; end
				1: begin qv = 1; dv = 1; tv = 1; pv = 1; end
				2: begin qv = 255; dv = 255; tv = 255; pv = 255; end
				3: begin qv = 3; dv = 40; tv = 7; pv = 90; end
				default: begin
					qv = $urandom_range(1, 12);
					dv = $urandom_range(1, 60);
					tv = $urandom_range(1, 60);
					pv = $urandom_range(1, 60);
				end
			endcase
			write_settings(qv, dv, tv, pv);
			for (int i = 0; i < phase_len[ph]; i++)
				random_item();
			drain();
		end

		$display("%0d items sent over %0d settings, %0d results compared, %0d processes loaded",
			n_sent, N_PHASES + 1, checked, (n_adds < MAX_PROCS) ? n_adds : MAX_PROCS);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/tlfs_pkg.sv
rtl/core/tlfs_item_if.sv
rtl/core/tlfs_res_if.sv
rtl/core/tlfs_cfg_if.sv
rtl/core/tlfs_queue.sv
rtl/core/tlfs_cmd_fifo.sv
rtl/core/tlfs_front.sv
rtl/core/tlfs_back.sv
rtl/core/two_level_feedback_scheduler.sv
sim/tlfs_checker.sv
sim/tb_two_level_feedback_scheduler.sv
